### rtl/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled at the rising clock, masked while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression that must never be true at a clock edge
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/ffpa_pkg.sv
`default_nettype none

package ffpa_pkg;

  // widest segment address and size, enough for the largest pool
  localparam int SEG_AW      = 17;
  localparam int OFF_W       = 12;
  localparam int SPLIT_SLACK = 8;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_NOMATCH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic             operation;
    logic [OFF_W-1:0] request_size;
    logic [OFF_W-1:0] release_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] granted_offset;
  } rsp_t;

  typedef struct packed {
    logic [SEG_AW-1:0] start;
    logic [SEG_AW-1:0] size;
    logic              free;
  } seg_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic             tok_load;
    logic             tok_adv;
    logic             upd;
    logic             op;
    logic             split;
    logic [OFF_W-1:0] want;
    logic [OFF_W-1:0] offset;
    seg_t             new_seg;
  } ctl_t;

endpackage

`default_nettype wire

### rtl/ffpa_cell.sv
`default_nettype none

module ffpa_cell
  import ffpa_pkg::*;
#(
  parameter int IDX          = 0,
  parameter int IW           = 7,
  parameter int POOL_BYTES   = 4096,
  parameter int HEADER_BYTES = 24
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ctl_t          ctl,
  input  wire logic [IW-1:0] ptr,
  input  wire seg_t          left_seg,
  input  wire logic          left_tok,
  output seg_t               seg,
  output logic               tok,
  output logic               hit,
  output seg_t               hit_seg
);

  localparam logic [SEG_AW:0] HDR  = (SEG_AW+1)'(HEADER_BYTES);
  localparam logic [IW:0]     MYIX = (IW+1)'(IDX);

  seg_t seg_r, seg_nxt;
  logic tok_r, tok_nxt;
  logic match;
  logic at_ptr, after_ptr, next_ptr;

  always_comb begin
    if (ctl.tok_load) begin
      tok_nxt = (IDX == 0);
    end else if (ctl.tok_adv) begin
      tok_nxt = left_tok;
    end else begin
      tok_nxt = 1'b0;
    end
  end

  always_comb begin
    if (ctl.op == OP_ALLOC) begin
      match = seg_r.free && (seg_r.size >= SEG_AW'(ctl.want));
    end else begin
      match = (({1'b0, seg_r.start} + HDR) == (SEG_AW+1)'(ctl.offset));
    end
  end

  assign at_ptr    = (MYIX == {1'b0, ptr});
  assign after_ptr = (MYIX >  {1'b0, ptr});
  assign next_ptr  = (MYIX == ({1'b0, ptr} + (IW+1)'(1)));

  always_comb begin
    seg_nxt = seg_r;
    if (ctl.upd) begin
      if (at_ptr) begin
        if (ctl.op == OP_ALLOC) begin
          seg_nxt.free = 1'b0;
          if (ctl.split) begin
            seg_nxt.size = SEG_AW'(ctl.want);
          end
        end else begin
          seg_nxt.free = 1'b1;
        end
      end else if (ctl.split && after_ptr) begin
        // open a slot right after the split segment, the tail moves up one
        if (next_ptr) begin
          seg_nxt = ctl.new_seg;
        end else begin
          seg_nxt = left_seg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n && IDX == 0) begin
      seg_r.start <= '0;
      seg_r.size  <= SEG_AW'(POOL_BYTES - HEADER_BYTES);
      seg_r.free  <= 1'b1;
    end else begin
      seg_r <= seg_nxt;
    end
  end

  assign seg     = seg_r;
  assign tok     = tok_r;
  assign hit     = tok_r && match;
  assign hit_seg = hit ? seg_r : '0;

endmodule

`default_nettype wire

### rtl/first_fit_pool_allocator_top.sv
`default_nettype none

// First-fit pool allocator. The segment table lives in a row of MAX_SEGMENTS
// cells, one segment per cell, in address order. After a request is taken a
// search token walks the row one cell per clock, starting at cell 0, until it
// reaches the first fitting free segment (allocate) or the segment whose
// payload starts at the given offset (free), or runs past the last segment in
// use, so it examines from 1 up to the current segment count of segments, at
// most MAX_SEGMENTS. A hit updates the table in the S_UPD state; a split
// shifts every later segment one cell up in that same update. Hit or miss,
// the result then goes to the output register from S_RESP. One request is in
// flight at a time; the next one is taken in the cycle after the previous
// result has been placed in the output register, which waits while an earlier
// result is still stalled. The table needs no clearing after reset.
module first_fit_pool_allocator_top
  import ffpa_pkg::*;
#(
  parameter int POOL_BYTES   = 4096,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_SEGMENTS = 128
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_req,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_rsp
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [SEG_AW:0] HDR   = (SEG_AW+1)'(HEADER_BYTES);
  localparam logic [SEG_AW:0] SLACK = (SEG_AW+1)'(SPLIT_SLACK);

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [IW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  seg_t              hit_seg_r, hit_seg_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [OFF_W-1:0]  grant_r, grant_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_rsp_r, out_rsp_nxt;

  ctl_t              ctl;
  seg_t              segs     [MAX_SEGMENTS];
  logic              toks     [MAX_SEGMENTS];
  logic              hits     [MAX_SEGMENTS];
  seg_t              hit_segs [MAX_SEGMENTS];
  logic              hit_any;
  seg_t              hit_or;
  logic              last;
  logic              split;
  logic [SEG_AW:0]   pay_off;

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      seg_t left_seg;
      logic left_tok;
      if (g == 0) begin : g_first
        assign left_seg = '0;
        assign left_tok = 1'b0;
      end else begin : g_rest
        assign left_seg = segs[g-1];
        assign left_tok = toks[g-1];
      end
      ffpa_cell #(
        .IDX          (g),
        .IW           (IW),
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .ptr      (ptr_r),
        .left_seg (left_seg),
        .left_tok (left_tok),
        .seg      (segs[g]),
        .tok      (toks[g]),
        .hit      (hits[g]),
        .hit_seg  (hit_segs[g])
      );
    end
  endgenerate

  // at most one cell holds the token, so a plain or collects its segment
  always_comb begin
    hit_any = 1'b0;
    hit_or  = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      hit_any = hit_any | hits[i];
      hit_or  = hit_or | hit_segs[i];
    end
  end

  assign last    = ((CW'(ptr_r) + CW'(1)) == cnt_r);
  assign pay_off = {1'b0, hit_seg_r.start} + HDR;
  assign split   = (req_r.operation == OP_ALLOC) &&
                   ({1'b0, hit_seg_r.size} > ((SEG_AW+1)'(req_r.request_size) + HDR + SLACK)) &&
                   (cnt_r < CW'(MAX_SEGMENTS));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit_any) begin
          state_nxt = S_UPD;
        end else if (last) begin
          state_nxt = S_RESP;
        end
      end
      S_UPD: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl               = '0;
    ctl.op            = req_r.operation;
    ctl.want          = req_r.request_size;
    ctl.offset        = req_r.release_offset;
    ctl.split         = split;
    ctl.new_seg.start = SEG_AW'(pay_off + (SEG_AW+1)'(req_r.request_size));
    ctl.new_seg.size  = SEG_AW'({1'b0, hit_seg_r.size} -
                                (SEG_AW+1)'(req_r.request_size) - HDR);
    ctl.new_seg.free  = 1'b1;

    req_nxt       = req_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    hit_seg_nxt   = hit_seg_r;
    status_nxt    = status_r;
    grant_nxt     = grant_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.tok_load = 1'b1;
          req_nxt      = in_req;
          ptr_nxt      = '0;
        end
      end
      S_SCAN: begin
        if (hit_any) begin
          hit_seg_nxt = hit_or;
        end else if (last) begin
          status_nxt = (req_r.operation == OP_ALLOC) ? ST_NOFIT : ST_NOMATCH;
          grant_nxt  = '0;
        end else begin
          ctl.tok_adv = 1'b1;
          ptr_nxt     = ptr_r + IW'(1);
        end
      end
      S_UPD: begin
        ctl.upd    = 1'b1;
        status_nxt = ST_DONE;
        grant_nxt  = (req_r.operation == OP_ALLOC) ? pay_off[OFF_W-1:0] : '0;
        if (split) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_rsp_nxt.status         = status_r;
          out_rsp_nxt.granted_offset = grant_r;
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    ptr_r     <= ptr_nxt;
    hit_seg_r <= hit_seg_nxt;
    status_r  <= status_nxt;
    grant_r   <= grant_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

`default_nettype wire

### rtl/ffpa_checker.sv
`default_nettype none

`include "assert_macros.svh"

module ffpa_checker
  import ffpa_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire req_t in_req,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire rsp_t out_rsp
);

  // a stalled result holds still
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_rsp), "result changed while stalled")

  // only a successful allocate carries an offset
  `ASSERT_NEVER(a_fail_zero, out_valid && out_rsp.status != ST_DONE && out_rsp.granted_offset != '0, "failed request with nonzero offset")

  // one request at a time: busy right after an accept
  `ASSERT_CLK(a_busy, in_valid && in_ready |=> !in_ready, "request taken while busy")

  // a waiting request holds still
  `ASSERT_CLK(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_req), "request changed while waiting")

  // only the defined status codes are reported
  `ASSERT_NEVER(a_status_known, out_valid && out_rsp.status > ST_NOMATCH, "undefined status code")

endmodule

bind first_fit_pool_allocator_top ffpa_checker u_ffpa_checker (.*);

`default_nettype wire

### tb/first_fit_pool_allocator_top_tb.sv
`timescale 1ns / 1ps

module first_fit_pool_allocator_top_tb;
  import ffpa_pkg::*;

  localparam int POOL_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_SEGMENTS = 128;
  localparam int DRAIN_CYCLES = MAX_SEGMENTS + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_rsp;

  first_fit_pool_allocator_top #(
    .POOL_BYTES  (POOL_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

  // shadow copy of the segment table
  bit [SEG_AW-1:0] seg_start [MAX_SEGMENTS];
  bit [SEG_AW-1:0] seg_size  [MAX_SEGMENTS];
  bit              seg_free  [MAX_SEGMENTS];
  int              seg_count;

  rsp_t pending_rsp_q[$];
  int   live_offset_q[$];
  int   mismatch_count = 0;
  bit   no_idle = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic reset_pool_shadow();
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      seg_start[i] = '0;
      seg_size[i]  = '0;
      seg_free[i]  = 1'b0;
    end
    seg_size[0] = POOL_BYTES - HEADER_BYTES;
    seg_free[0] = 1'b1;
    seg_count   = 1;
  endtask

  function automatic rsp_t pool_grant(input int want);
    rsp_t r;
    int   have;
    r.status         = ST_NOFIT;
    r.granted_offset = '0;
    for (int i = 0; i < seg_count; i++) begin
      if (seg_free[i] && int'(seg_size[i]) >= want) begin
        have = int'(seg_size[i]);
        if (have > want + HEADER_BYTES + SPLIT_SLACK && seg_count < MAX_SEGMENTS) begin
          // open a slot right after the hit for the leftover
          for (int k = seg_count; k > i + 1; k--) begin
            seg_start[k] = seg_start[k-1];
            seg_size[k]  = seg_size[k-1];
            seg_free[k]  = seg_free[k-1];
          end
          seg_start[i+1] = seg_start[i] + HEADER_BYTES + want;
          seg_size[i+1]  = have - want - HEADER_BYTES;
          seg_free[i+1]  = 1'b1;
          seg_count++;
          seg_size[i] = want;
        end
        seg_free[i]      = 1'b0;
        r.status         = ST_DONE;
        r.granted_offset = OFF_W'(seg_start[i] + HEADER_BYTES);
        return r;
      end
    end
    return r;
  endfunction

  function automatic rsp_t pool_release(input int offset);
    rsp_t r;
    r.status         = ST_NOMATCH;
    r.granted_offset = '0;
    for (int i = 0; i < seg_count; i++) begin
      if (int'(seg_start[i]) + HEADER_BYTES == offset) begin
        seg_free[i] = 1'b1;
        r.status    = ST_DONE;
        return r;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 96) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // leaves valid high on return when the next request follows back to back
  task automatic send_request(input req_t r);
    rsp_t exp_rsp;
    int   gap;
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    if (r.operation == OP_ALLOC) begin
      exp_rsp = pool_grant(int'(r.request_size));
      if (exp_rsp.status == ST_DONE) live_offset_q.push_back(int'(exp_rsp.granted_offset));
    end else begin
      exp_rsp = pool_release(int'(r.release_offset));
    end
    pending_rsp_q.push_back(exp_rsp);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_alloc(input int want);
    req_t r;
    r.operation      = OP_ALLOC;
    r.request_size   = OFF_W'(want);
    r.release_offset = OFF_W'($urandom_range(4095));
    send_request(r);
  endtask

  task automatic send_free(input int offset);
    req_t r;
    r.operation      = OP_FREE;
    r.request_size   = OFF_W'($urandom_range(4095));
    r.release_offset = OFF_W'(offset);
    send_request(r);
  endtask

  // sender holds off until every pending result is back
  task automatic drain_results();
    if (pending_rsp_q.size() != 0) begin
      in_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clk);
    end
  endtask

  task automatic test_fresh_pool();
    send_alloc(0);
    send_alloc(4095);
    send_alloc(4049);
    send_free(0);
    send_free(4095);
    send_free(30);
    send_free(24);
    send_free(24);
    send_alloc(0);
    drain_results();
  endtask

  // leftover of exactly header plus slack must not split, one more byte must
  task automatic test_split_boundary();
    send_alloc(100);
    send_alloc(60);
    send_free(48);
    send_alloc(100);
    send_free(48);
    send_alloc(68);
    send_free(48);
    send_alloc(67);
    drain_results();
  endtask

  task automatic test_table_full();
    int idx;
    int tries;
    tries = 0;
    while (seg_count < MAX_SEGMENTS && tries < 500) begin
      if ($urandom_range(9) < 7 || live_offset_q.size() == 0) begin
        send_alloc($urandom_range(3));
      end else begin
        idx = $urandom_range(live_offset_q.size() - 1);
        send_free(live_offset_q[idx]);
        live_offset_q.delete(idx);
      end
      tries++;
    end
    // full table grants whole segments
    send_alloc(1);
    send_alloc($urandom_range(200));
    send_alloc(4095);
    drain_results();
  endtask

  task automatic test_random_traffic(input int n_items);
    int p;
    int q;
    int idx;
    int off;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(3) == 0);
      if (i == n_items / 2) drain_results();
      p = $urandom_range(99);
      if (p < 50) begin
        q = $urandom_range(99);
        if (q < 60) send_alloc($urandom_range(16));
        else if (q < 90) send_alloc($urandom_range(300));
        else send_alloc($urandom_range(4095));
      end else if (p < 82 && live_offset_q.size() > 0) begin
        idx = $urandom_range(live_offset_q.size() - 1);
        off = live_offset_q[idx];
        // some stay listed so they get released twice
        if ($urandom_range(4) != 0) live_offset_q.delete(idx);
        send_free(off);
      end else begin
        if (p < 91 && live_offset_q.size() > 0) begin
          off = live_offset_q[$urandom_range(live_offset_q.size() - 1)];
          off = off + $urandom_range(6) - 3;
          if (off < 0) off = 0;
          if (off > 4095) off = 4095;
        end else begin
          off = $urandom_range(4095);
        end
        send_free(off);
      end
    end
    no_idle = 1'b0;
    drain_results();
  endtask

  initial begin
    int run;
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      run = ($urandom_range(7) == 0) ? $urandom_range(600, 200) : $urandom_range(20, 1);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d offset %0d",
                   out_rsp.status, out_rsp.granted_offset);
      end else begin
        if (out_rsp.status !== pending_rsp_q[0].status ||
            out_rsp.granted_offset !== pending_rsp_q[0].granted_offset) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d offset %0d, got status %0d offset %0d",
                     pending_rsp_q[0].status, pending_rsp_q[0].granted_offset,
                     out_rsp.status, out_rsp.granted_offset);
        end
        void'(pending_rsp_q.pop_front());
      end
    end
  end

  initial begin
    reset_pool_shadow();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fresh_pool();
    test_split_boundary();
    test_table_full();
    test_random_traffic(560);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
